// ===== design/tms_pkg.sv =====
// Shared types and constants for the transfer message scanner.
// Used by tms_parser, tms_emitter and transfer_message_scanner; no dependencies.

package tms_pkg;

    localparam int MAX_ACCOUNTS_DEF = 64;

    localparam int HDR_BYTES       = 3;
    localparam int KEY_BYTES       = 32;
    localparam int HASH_BYTES      = 32;
    localparam int KEY_WORDS       = 4;
    localparam int TRANSFER_LEN    = 12;
    localparam int AMOUNT_OFFSET   = 4;
    localparam int TAG_BYTES       = 4;
    localparam logic [7:0] TRANSFER_TAG = 8'h02;

    localparam int CNT_W    = 21;
    localparam int WORD_W   = 64;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 8;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_NACC,
        PH_KEYS,
        PH_HASH,
        PH_NINS,
        PH_PROG,
        PH_NIA,
        PH_IACC,
        PH_DLEN,
        PH_DATA,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NONE      = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_VERSIONED = 3'd3,
        ST_TOOMANY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_FETCH,
        EM_DRAIN
    } t_emit_state;

    // Message summary handed from the parser to the result stage
    typedef struct packed {
        t_status           status;
        logic [7:0]        recipient;
        logic [WORD_W-1:0] amount;
    } t_summary;

endpackage

// ===== design/tms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tms_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tms_parser.sv =====
// Byte-wise field walker: header, account keys, blockhash and instruction list.
// Depends on tms_pkg; drives the key store and zero-flag RAM write ports.

module tms_parser
    import tms_pkg::*;
#(
    parameter  int MAX_ACCOUNTS = MAX_ACCOUNTS_DEF,
    localparam int AW  = $clog2(MAX_ACCOUNTS),
    localparam int KAW = AW + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_key_we,
    output logic [KAW-1:0]    o_key_waddr,
    output logic [WORD_W-1:0] o_key_wdata,
    output logic              o_zero_we,
    output logic [AW-1:0]     o_zero_waddr,
    output logic              o_zero_wdata,
    output logic              o_zero_re,
    output logic [AW-1:0]     o_zero_raddr,
    input  logic              i_zero_rdata,
    output logic              o_sum_valid,
    output t_summary          o_sum
);

    localparam int PW = AW + 5;
    localparam int CW = $clog2(MAX_ACCOUNTS + 1);

    t_phase            r_phase, n_phase;
    logic [PW-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]  r_vval, n_vval;
    logic [1:0]        r_vused, n_vused;
    logic [CW-1:0]     r_acnt, n_acnt;
    logic [CNT_W-1:0]  r_fbl, n_fbl;
    logic [CNT_W-1:0]  r_ins, n_ins;
    logic [7:0]        r_prog, n_prog;
    logic              r_two, n_two;
    logic [7:0]        r_second, n_second;
    logic              r_dlen12, n_dlen12;
    logic              r_prefix, n_prefix;
    logic [WORD_W-1:0] r_amount, n_amount;
    logic [WORD_W-1:0] r_kword, n_kword;
    logic              r_zrun, n_zrun;
    logic              r_found, n_found;
    logic [7:0]        r_rec, n_rec;
    logic [WORD_W-1:0] r_famt, n_famt;
    t_status           r_err, n_err;

    logic [CNT_W-1:0]  v_full;
    logic              v_done;
    logic              v_over;
    logic              v_phase;

    // compact-u16 decode: low 7-bit group first
    always_comb begin
        case (r_vused)
            2'd0:    v_full = r_vval | {14'b0, i_byte[6:0]};
            2'd1:    v_full = r_vval | {7'b0, i_byte[6:0], 7'b0};
            default: v_full = r_vval | {i_byte[6:0], 14'b0};
        endcase
    end

    assign v_done  = ~i_byte[7];
    assign v_over  = i_byte[7] && (r_vused == 2'd2);
    assign v_phase = (r_phase == PH_NACC) || (r_phase == PH_NINS) ||
                     (r_phase == PH_NIA) || (r_phase == PH_DLEN);

    // next state
    always_comb begin
        logic       do_finish;
        logic       hit;
        logic [2:0] lane;
        logic [2:0] apos;

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_vval   = r_vval;
        n_vused  = r_vused;
        n_acnt   = r_acnt;
        n_fbl    = r_fbl;
        n_ins    = r_ins;
        n_prog   = r_prog;
        n_two    = r_two;
        n_second = r_second;
        n_dlen12 = r_dlen12;
        n_prefix = r_prefix;
        n_amount = r_amount;
        n_kword  = r_kword;
        n_zrun   = r_zrun;
        n_found  = r_found;
        n_rec    = r_rec;
        n_famt   = r_famt;
        n_err    = r_err;
        do_finish = 1'b0;
        hit       = 1'b0;
        lane      = r_pos[2:0];
        apos      = 3'(r_pos - PW'(AMOUNT_OFFSET));

        if (i_accept) begin
            if (v_phase) begin
                if (v_done) begin
                    n_vval  = '0;
                    n_vused = '0;
                end else if (v_over) begin
                    n_vval  = '0;
                    n_vused = '0;
                    n_err   = ST_MALFORMED;
                    n_phase = PH_ERR;
                end else begin
                    n_vval  = v_full;
                    n_vused = 2'(r_vused + 2'd1);
                end
            end

            case (r_phase)
                PH_HDR: begin
                    if (r_pos == '0 && i_byte[7]) begin
                        n_err   = ST_VERSIONED;
                        n_phase = PH_ERR;
                    end else if (r_pos == PW'(HDR_BYTES - 1)) begin
                        n_pos   = '0;
                        n_phase = PH_NACC;
                    end else begin
                        n_pos = PW'(r_pos + PW'(1));
                    end
                end
                PH_NACC: begin
                    if (v_done) begin
                        if (v_full > CNT_W'(MAX_ACCOUNTS)) begin
                            n_err   = ST_TOOMANY;
                            n_phase = PH_ERR;
                        end else begin
                            n_acnt = CW'(v_full);
                            n_pos  = '0;
                            if (v_full == '0) begin
                                n_fbl   = CNT_W'(HASH_BYTES);
                                n_phase = PH_HASH;
                            end else begin
                                n_fbl   = {v_full[15:0], 5'b0};
                                n_phase = PH_KEYS;
                            end
                        end
                    end
                end
                PH_KEYS: begin
                    // assemble one 64-bit key word, low byte first
                    n_kword = (lane == 3'd0) ? '0 : r_kword;
                    n_kword[{lane, 3'b0} +: 8] = i_byte;
                    n_zrun  = ((r_pos[4:0] == 5'd0) || r_zrun) && (i_byte == 8'd0);
                    n_pos   = PW'(r_pos + PW'(1));
                    n_fbl   = CNT_W'(r_fbl - CNT_W'(1));
                    if (r_fbl == CNT_W'(1)) begin
                        n_fbl   = CNT_W'(HASH_BYTES);
                        n_phase = PH_HASH;
                    end
                end
                PH_HASH: begin
                    n_fbl = CNT_W'(r_fbl - CNT_W'(1));
                    if (r_fbl == CNT_W'(1)) begin
                        n_phase = PH_NINS;
                    end
                end
                PH_NINS: begin
                    if (v_done) begin
                        n_ins   = v_full;
                        n_phase = (v_full == '0) ? PH_DONE : PH_PROG;
                    end
                end
                PH_PROG: begin
                    n_prog  = i_byte;
                    n_phase = PH_NIA;
                end
                PH_NIA: begin
                    if (v_done) begin
                        n_two    = (v_full >= CNT_W'(2));
                        n_second = '0;
                        n_pos    = '0;
                        if (v_full == '0) begin
                            n_phase = PH_DLEN;
                        end else begin
                            n_fbl   = v_full;
                            n_phase = PH_IACC;
                        end
                    end
                end
                PH_IACC: begin
                    if (r_pos == PW'(1)) begin
                        n_second = i_byte;
                    end
                    if (r_pos < PW'(2)) begin
                        n_pos = PW'(r_pos + PW'(1));
                    end
                    n_fbl = CNT_W'(r_fbl - CNT_W'(1));
                    if (r_fbl == CNT_W'(1)) begin
                        n_phase = PH_DLEN;
                    end
                end
                PH_DLEN: begin
                    if (v_done) begin
                        n_dlen12 = (v_full == CNT_W'(TRANSFER_LEN));
                        n_prefix = 1'b1;
                        n_amount = '0;
                        n_pos    = '0;
                        if (v_full == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_fbl   = v_full;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (r_pos < PW'(TAG_BYTES)) begin
                        if (i_byte != ((r_pos == '0) ? TRANSFER_TAG : 8'd0)) begin
                            n_prefix = 1'b0;
                        end
                    end else if (r_pos < PW'(TRANSFER_LEN)) begin
                        n_amount[{apos, 3'b0} +: 8] = i_byte;
                    end
                    if (r_pos < PW'(TRANSFER_LEN)) begin
                        n_pos = PW'(r_pos + PW'(1));
                    end
                    n_fbl = CNT_W'(r_fbl - CNT_W'(1));
                    if (r_fbl == CNT_W'(1)) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (do_finish) begin
                hit = ({1'b0, r_prog} < 9'(r_acnt)) && i_zero_rdata && n_dlen12 &&
                      n_prefix && n_two && ({1'b0, n_second} < 9'(r_acnt));
                if (hit) begin
                    n_found = 1'b1;
                    n_rec   = n_second;
                    n_famt  = n_amount;
                    n_phase = PH_DONE;
                end else begin
                    n_ins   = CNT_W'(r_ins - CNT_W'(1));
                    n_phase = (r_ins == CNT_W'(1)) ? PH_DONE : PH_PROG;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_key_we     = i_accept && (r_phase == PH_KEYS) && (r_pos[2:0] == 3'd7);
        o_key_waddr  = r_pos[PW-1:3];
        o_key_wdata  = n_kword;
        o_zero_we    = i_accept && (r_phase == PH_KEYS) && (r_pos[4:0] == 5'd31);
        o_zero_waddr = r_pos[PW-1:5];
        o_zero_wdata = n_zrun;
        o_zero_re    = i_accept && (r_phase == PH_PROG);
        o_zero_raddr = i_byte[AW-1:0];

        o_sum_valid = i_accept && i_last;
        if (n_phase == PH_ERR) begin
            o_sum.status = n_err;
        end else if (n_found) begin
            o_sum.status = ST_FOUND;
        end else if (n_phase == PH_DONE) begin
            o_sum.status = ST_NONE;
        end else begin
            o_sum.status = ST_MALFORMED;
        end
        o_sum.recipient = n_rec;
        o_sum.amount    = n_famt;
    end

    // restart the parse after the final byte of each message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase  <= PH_HDR;
            r_pos    <= '0;
            r_vval   <= '0;
            r_vused  <= '0;
            r_acnt   <= '0;
            r_fbl    <= '0;
            r_ins    <= '0;
            r_prog   <= '0;
            r_two    <= 1'b0;
            r_second <= '0;
            r_dlen12 <= 1'b0;
            r_prefix <= 1'b1;
            r_amount <= '0;
            r_zrun   <= 1'b0;
            r_found  <= 1'b0;
            r_rec    <= '0;
            r_famt   <= '0;
            r_err    <= ST_FOUND;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_vval   <= n_vval;
            r_vused  <= n_vused;
            r_acnt   <= n_acnt;
            r_fbl    <= n_fbl;
            r_ins    <= n_ins;
            r_prog   <= n_prog;
            r_two    <= n_two;
            r_second <= n_second;
            r_dlen12 <= n_dlen12;
            r_prefix <= n_prefix;
            r_amount <= n_amount;
            r_zrun   <= n_zrun;
            r_found  <= n_found;
            r_rec    <= n_rec;
            r_famt   <= n_famt;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kword <= n_kword;
    end

endmodule

// ===== design/tms_emitter.sv =====
// Result stage: fetches the recipient key words and streams four result words.
// Depends on tms_pkg; reads the key store RAM.

module tms_emitter
    import tms_pkg::*;
#(
    parameter  int MAX_ACCOUNTS = MAX_ACCOUNTS_DEF,
    localparam int AW  = $clog2(MAX_ACCOUNTS),
    localparam int KAW = AW + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sum_valid,
    input  t_summary              i_sum,
    output logic                  o_idle,
    output logic                  o_rd_en,
    output logic [KAW-1:0]        o_rd_addr,
    input  logic [WORD_W-1:0]     i_rd_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [OUT_USER_W-1:0] o_m_tuser,
    output logic                  o_m_tlast
);

    t_emit_state       r_state, n_state;
    logic [2:0]        r_cnt;
    logic              r_rd_pend;
    logic [1:0]        r_rd_k;
    logic [WORD_W-1:0] r_buf [KEY_WORDS];
    t_status           r_status;
    logic [7:0]        r_rec;
    logic [WORD_W-1:0] r_amount;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_last;

    logic              load;
    logic              found;
    logic [WORD_W-1:0] word;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            EM_IDLE: begin
                if (i_sum_valid) begin
                    n_state = EM_FETCH;
                end
            end
            EM_FETCH: begin
                if (r_rd_pend && (r_rd_k == 2'd3)) begin
                    n_state = EM_DRAIN;
                end
            end
            EM_DRAIN: begin
                if (load && (r_cnt[1:0] == 2'd3)) begin
                    n_state = EM_IDLE;
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle    = (r_state == EM_IDLE);
        o_rd_en   = (r_state == EM_FETCH) && !r_cnt[2];
        o_rd_addr = {r_rec[AW-1:0], r_cnt[1:0]};
        load      = (r_state == EM_DRAIN) && (!r_out_valid || i_m_tready);
        found     = (r_status == ST_FOUND);
        word      = found ? r_buf[r_cnt[1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_cnt       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= o_rd_en;
            if (r_state == EM_IDLE) begin
                r_cnt <= '0;
            end else if (o_rd_en || load) begin
                r_cnt <= 3'(r_cnt + 3'd1);
            end else if (n_state == EM_DRAIN && r_state == EM_FETCH) begin
                r_cnt <= '0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == EM_IDLE && i_sum_valid) begin
            r_status <= i_sum.status;
            r_rec    <= i_sum.recipient;
            r_amount <= i_sum.amount;
        end
        r_rd_k <= r_cnt[1:0];
        if (r_rd_pend) begin
            r_buf[r_rd_k] <= i_rd_data;
        end
        if (load) begin
            r_out_data <= {found ? r_amount : {WORD_W{1'b0}}, word};
            r_out_user <= {3'b0, r_status, r_cnt[1:0]};
            r_out_last <= (r_cnt[1:0] == 2'd3);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/transfer_message_scanner.sv =====
// Transfer message scanner top level: parser, key store RAMs and result stage.
// Depends on tms_pkg, tms_ram, tms_parser and tms_emitter.
//
// Usage:
//   Input stream: one message byte per word on s_axis, tlast on the final
//   byte. Bytes are taken back to back, but a final byte may be held off.
//   Output stream: four words per message on m_axis, word_index 0..3, with
//   tlast on the fourth. tdata carries a quarter of the recipient key and the
//   amount; tuser carries word_index and the status code.
//   Result timing: after the final byte the result stage reads the four key
//   words through the key store's single registered read port, then loads
//   one result per cycle while m_axis is ready.
//   Throughput: one byte per cycle. A final byte is held off (tready low while
//   tlast is high) until the results of the previous message have all been
//   fetched and loaded toward the output; other bytes of the next message keep
//   flowing meanwhile.
//   Receiver stall: the result word holds in the output register and the
//   result stage waits; the input side is only held at the next final byte.
//   Reset: synchronous, active low; clears the parse and the result stage.
//   Key store contents are not cleared and need no clearing pass.

module transfer_message_scanner
    import tms_pkg::*;
#(
    parameter int MAX_ACCOUNTS = MAX_ACCOUNTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] msg_byte
    input  logic                  i_s_axis_tlast,   // end_of_message
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [63:0] recipient_word, [127:64] amount
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,   // [1:0] word_index, [4:2] status, [7:5] zero
    output logic                  o_m_axis_tlast    // last_result
);

    localparam int AW  = $clog2(MAX_ACCOUNTS);
    localparam int KAW = AW + 2;

    logic              accept;
    logic              emit_idle;
    logic              key_we;
    logic [KAW-1:0]    key_waddr;
    logic [WORD_W-1:0] key_wdata;
    logic              key_re;
    logic [KAW-1:0]    key_raddr;
    logic [WORD_W-1:0] key_rdata;
    logic              zero_we;
    logic [AW-1:0]     zero_waddr;
    logic              zero_wdata;
    logic              zero_re;
    logic [AW-1:0]     zero_raddr;
    logic              zero_rdata;
    logic              sum_valid;
    t_summary          sum;

    // hold a final byte while the result stage is busy
    assign o_s_axis_tready = emit_idle || !i_s_axis_tlast;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    tms_parser #(
        .MAX_ACCOUNTS(MAX_ACCOUNTS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_s_axis_tdata),
        .i_last       (i_s_axis_tlast),
        .o_key_we     (key_we),
        .o_key_waddr  (key_waddr),
        .o_key_wdata  (key_wdata),
        .o_zero_we    (zero_we),
        .o_zero_waddr (zero_waddr),
        .o_zero_wdata (zero_wdata),
        .o_zero_re    (zero_re),
        .o_zero_raddr (zero_raddr),
        .i_zero_rdata (zero_rdata),
        .o_sum_valid  (sum_valid),
        .o_sum        (sum)
    );

    tms_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_ACCOUNTS * KEY_WORDS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    tms_ram #(
        .WIDTH(1),
        .DEPTH(MAX_ACCOUNTS)
    ) u_zero_ram (
        .i_clk   (i_clk),
        .i_we    (zero_we),
        .i_waddr (zero_waddr),
        .i_wdata (zero_wdata),
        .i_re    (zero_re),
        .i_raddr (zero_raddr),
        .o_rdata (zero_rdata)
    );

    tms_emitter #(
        .MAX_ACCOUNTS(MAX_ACCOUNTS)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_valid (sum_valid),
        .i_sum       (sum),
        .o_idle      (emit_idle),
        .o_rd_en     (key_re),
        .o_rd_addr   (key_raddr),
        .i_rd_data   (key_rdata),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

// ===== tb/transfer_message_scanner_tb.sv =====
// Self-checking testbench for transfer_message_scanner: builds serialized messages,
// predicts the four result words of each one and checks them on the output stream.
// Depends on tms_pkg and the transfer_message_scanner RTL.

module transfer_message_scanner_tb;
    import tms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACCTS              = MAX_ACCOUNTS_DEF;
    localparam int COUNT_MAX_BYTES    = 3;
    localparam int MIN_TRANSFER_ACCTS = 2;
    localparam int RX_HOLD            = 300;
    localparam int QUIET_LIMIT        = 2000;
    localparam int DRAIN_CYCLES       = 20;
    localparam int IDLE_PCT           = 11;
    localparam int RANDOM_BYTES       = 380;
    localparam int RANDOM_MSGS        = 12;
    localparam int MAX_PRINTS         = 40;

    typedef enum {FILL_ZERO, FILL_RAND, FILL_ONES} t_key_fill;
    typedef enum {FL_NONE, FL_TAG, FL_SHORT, FL_LONG, FL_ONE_ACCT} t_flaw;

    typedef struct {
        logic [1:0]  idx;
        logic [63:0] rcpt_word;
        logic [63:0] amount;
        t_status     status;
        logic        last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;    // [7:0] msg_byte
    logic                  i_s_axis_tlast = 1'b0;  // end_of_message
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // [63:0] recipient_word, [127:64] amount
    logic [OUT_USER_W-1:0] o_m_axis_tuser;   // [1:0] word_index, [4:2] status, [7:5] zero
    logic                  o_m_axis_tlast;   // last_result

    transfer_message_scanner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Scan predictor state
    // ---------------------------------------------------------------
    t_phase      parse_ph;
    logic [15:0] pos_cnt;
    logic [20:0] count_acc;
    logic [1:0]  count_bytes;
    logic [20:0] acct_total;
    logic [20:0] bytes_left;
    logic [20:0] instr_left;
    logic [7:0]  prog_idx;
    logic [20:0] instr_accts;
    logic [7:0]  rcpt_idx;
    logic [20:0] data_len;
    logic        tag_ok;
    logic [63:0] amount_acc;
    logic [63:0] key_words [ACCTS*KEY_WORDS];
    logic        key_zero [ACCTS];
    logic        xfer_found;
    logic [7:0]  xfer_rcpt;
    logic [63:0] xfer_amount;
    logic        scan_failed;
    t_status     fail_status;

    t_result     expected_results[$];
    logic [7:0]  msg_buf[$];
    int          fail_count = 0;
    bit          no_idle = 1'b0;
    int          holds_asked = 0;

    function automatic void clear_scan();
        parse_ph    = PH_HDR;
        pos_cnt     = '0;
        count_acc   = '0;
        count_bytes = '0;
        acct_total  = '0;
        bytes_left  = '0;
        instr_left  = '0;
        prog_idx    = '0;
        instr_accts = '0;
        rcpt_idx    = '0;
        data_len    = '0;
        tag_ok      = 1'b1;
        amount_acc  = '0;
        xfer_found  = 1'b0;
        xfer_rcpt   = '0;
        xfer_amount = '0;
        scan_failed = 1'b0;
        fail_status = ST_FOUND;
    endfunction

    function automatic void flag_error(input t_status code);
        scan_failed = 1'b1;
        fail_status = code;
        parse_ph    = PH_ERR;
    endfunction

    // Compact-u16 decoder: 7 bits per byte, low group first, bit 7 = more.
    function automatic bit take_count_byte(input logic [7:0] b, output logic [20:0] val);
        val = '0;
        count_acc = count_acc | (21'(b[6:0]) << (7 * count_bytes));
        count_bytes++;
        if (!b[7]) begin
            val = count_acc;
            count_acc = '0;
            count_bytes = '0;
            return 1'b1;
        end
        if (count_bytes >= COUNT_MAX_BYTES) begin
            count_acc = '0;
            count_bytes = '0;
            flag_error(ST_MALFORMED);
        end
        return 1'b0;
    endfunction

    function automatic void close_instruction();
        if (prog_idx < acct_total && prog_idx < ACCTS && key_zero[prog_idx[5:0]] &&
            data_len == TRANSFER_LEN && tag_ok && instr_accts >= MIN_TRANSFER_ACCTS &&
            rcpt_idx < acct_total) begin
            xfer_found  = 1'b1;
            xfer_rcpt   = rcpt_idx;
            xfer_amount = amount_acc;
            parse_ph    = PH_DONE;
        end else begin
            instr_left = instr_left - 1'b1;
            parse_ph = (instr_left == 0) ? PH_DONE : PH_PROG;
        end
    endfunction

    // Advance the predicted parse by one byte; queue the four results on the final byte.
    function automatic void scan_byte(input logic [7:0] b, input bit eom);
        logic [20:0] v;
        int          acct;
        int          kb;
        t_status     st;
        t_result     r;
        case (parse_ph)
            PH_HDR: begin
                if (pos_cnt == 0 && b[7]) begin
                    flag_error(ST_VERSIONED);
                end else begin
                    pos_cnt++;
                    if (pos_cnt >= HDR_BYTES) begin
                        pos_cnt = '0;
                        parse_ph = PH_NACC;
                    end
                end
            end
            PH_NACC: if (take_count_byte(b, v)) begin
                acct_total = v;
                if (v > ACCTS) begin
                    flag_error(ST_TOOMANY);
                end else begin
                    pos_cnt = '0;
                    if (v == 0) begin
                        bytes_left = HASH_BYTES;
                        parse_ph = PH_HASH;
                    end else begin
                        bytes_left = 21'(v * KEY_BYTES);
                        parse_ph = PH_KEYS;
                    end
                end
            end
            PH_KEYS: begin
                acct = (int'(pos_cnt) / KEY_BYTES) % ACCTS;
                kb = int'(pos_cnt) % KEY_BYTES;
                if (kb == 0) key_zero[acct] = 1'b1;
                if (kb % 8 == 0) key_words[acct*KEY_WORDS + kb/8] = '0;
                key_words[acct*KEY_WORDS + kb/8][8*(kb%8) +: 8] = b;
                if (b != 0) key_zero[acct] = 1'b0;
                pos_cnt++;
                bytes_left--;
                if (bytes_left == 0) begin
                    bytes_left = HASH_BYTES;
                    parse_ph = PH_HASH;
                end
            end
            PH_HASH: begin
                bytes_left--;
                if (bytes_left == 0) parse_ph = PH_NINS;
            end
            PH_NINS: if (take_count_byte(b, v)) begin
                instr_left = v;
                parse_ph = (v == 0) ? PH_DONE : PH_PROG;
            end
            PH_PROG: begin
                prog_idx = b;
                parse_ph = PH_NIA;
            end
            PH_NIA: if (take_count_byte(b, v)) begin
                instr_accts = v;
                rcpt_idx = '0;
                pos_cnt = '0;
                if (v == 0) begin
                    parse_ph = PH_DLEN;
                end else begin
                    bytes_left = v;
                    parse_ph = PH_IACC;
                end
            end
            PH_IACC: begin
                if (pos_cnt == 1) rcpt_idx = b;
                if (pos_cnt < 2) pos_cnt++;
                bytes_left--;
                if (bytes_left == 0) parse_ph = PH_DLEN;
            end
            PH_DLEN: if (take_count_byte(b, v)) begin
                data_len = v;
                tag_ok = 1'b1;
                amount_acc = '0;
                pos_cnt = '0;
                if (v == 0) begin
                    close_instruction();
                end else begin
                    bytes_left = v;
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA: begin
                if (pos_cnt < TAG_BYTES) begin
                    if (b != ((pos_cnt == 0) ? TRANSFER_TAG : 8'h00)) tag_ok = 1'b0;
                end else if (pos_cnt < TRANSFER_LEN) begin
                    amount_acc[8*(pos_cnt-AMOUNT_OFFSET) +: 8] = b;
                end
                if (pos_cnt < TRANSFER_LEN) pos_cnt++;
                bytes_left--;
                if (bytes_left == 0) close_instruction();
            end
            default: ;
        endcase

        if (eom) begin
            if (scan_failed) st = fail_status;
            else if (xfer_found) st = ST_FOUND;
            else if (parse_ph == PH_DONE) st = ST_NONE;
            else st = ST_MALFORMED;
            for (int k = 0; k < KEY_WORDS; k++) begin
                r.idx = 2'(k);
                r.rcpt_word = '0;
                if (st == ST_FOUND && xfer_rcpt < ACCTS)
                    r.rcpt_word = key_words[int'(xfer_rcpt)*KEY_WORDS + k];
                r.amount = (st == ST_FOUND) ? xfer_amount : 64'd0;
                r.status = st;
                r.last = (k == KEY_WORDS - 1);
                expected_results.push_back(r);
            end
            clear_scan();
        end
    endfunction

    // ---------------------------------------------------------------
    // Message builders
    // ---------------------------------------------------------------
    function automatic void put_random(input int n);
        for (int i = 0; i < n; i++) msg_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void put_header();
        msg_buf.push_back(8'($urandom_range(127)));
        put_random(2);
    endfunction

    // Encode a count, padded to at least min_len bytes (non-minimal forms are legal).
    function automatic void put_count(input int v, input int min_len);
        int n;
        logic [7:0] b;
        n = (v < 128) ? 1 : (v < 16384) ? 2 : 3;
        if (min_len > n) n = min_len;
        for (int i = 0; i < n; i++) begin
            b = 8'((v >> (7 * i)) & 'h7f);
            if (i < n - 1) b[7] = 1'b1;
            msg_buf.push_back(b);
        end
    endfunction

    function automatic int pick_width();
        return ($urandom_range(9) == 0) ? int'($urandom_range(COUNT_MAX_BYTES)) : 0;
    endfunction

    function automatic void put_key(input t_key_fill fill);
        for (int i = 0; i < KEY_BYTES; i++) begin
            case (fill)
                FILL_ZERO: msg_buf.push_back(8'h00);
                FILL_ONES: msg_buf.push_back(8'hff);
                default:   msg_buf.push_back(8'($urandom_range(255)));
            endcase
        end
    endfunction

    function automatic void put_instr(input int prog, input int naccts, input int dlen);
        msg_buf.push_back(8'(prog));
        put_count(naccts, pick_width());
        put_random(naccts);
        put_count(dlen, pick_width());
        put_random(dlen);
    endfunction

    function automatic void put_transfer(input int prog, input int recip,
                                         input logic [63:0] amt, input t_flaw flaw);
        int naccts;
        int dlen;
        logic [7:0] tag [TAG_BYTES];
        naccts = (flaw == FL_ONE_ACCT) ? 1 : MIN_TRANSFER_ACCTS + int'($urandom_range(2));
        dlen = (flaw == FL_SHORT) ? TRANSFER_LEN - 1 :
               (flaw == FL_LONG)  ? TRANSFER_LEN + 1 : TRANSFER_LEN;
        msg_buf.push_back(8'(prog));
        put_count(naccts, pick_width());
        put_random(1);
        if (naccts >= MIN_TRANSFER_ACCTS) msg_buf.push_back(8'(recip));
        put_random(naccts - MIN_TRANSFER_ACCTS);
        put_count(dlen, pick_width());
        tag[0] = TRANSFER_TAG;
        for (int i = 1; i < TAG_BYTES; i++) tag[i] = 8'h00;
        if (flaw == FL_TAG) tag[$urandom_range(TAG_BYTES-1)] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < TAG_BYTES; i++) msg_buf.push_back(tag[i]);
        for (int i = 0; i < dlen - AMOUNT_OFFSET; i++)
            msg_buf.push_back((i < 8) ? amt[8*i +: 8] : 8'($urandom_range(255)));
    endfunction

    function automatic logic [63:0] rand_amount();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed messages with random content; some noise, cut or damaged.
    function automatic void put_random_message();
        int n_acc;
        int zero_idx;
        int n_ins;
        int sel;
        int prog;
        int recip;
        int cut;
        sel = $urandom_range(99);
        if (sel < 10) begin
            msg_buf.push_back(8'($urandom_range(255)));
            put_random($urandom_range(40));
            return;
        end
        sel = $urandom_range(99);
        n_acc = (sel < 5) ? 0 : (sel < 12) ? ACCTS : int'($urandom_range(1, 6));
        zero_idx = (n_acc == 0) ? 0 : int'($urandom_range(n_acc - 1));
        put_header();
        put_count(n_acc, pick_width());
        for (int a = 0; a < n_acc; a++)
            put_key((a == zero_idx || $urandom_range(9) == 0) ? FILL_ZERO : FILL_RAND);
        put_random(HASH_BYTES);
        n_ins = ($urandom_range(19) == 0) ? 0 : int'($urandom_range(1, 4));
        put_count(n_ins, pick_width());
        for (int i = 0; i < n_ins; i++) begin
            sel = $urandom_range(99);
            recip = (n_acc == 0) ? int'($urandom_range(3)) : int'($urandom_range(n_acc - 1));
            if (sel < 35) begin
                put_transfer(zero_idx, recip, rand_amount(), FL_NONE);
            end else if (sel < 60) begin
                case ($urandom_range(6))
                    0: put_transfer(zero_idx, recip, rand_amount(), FL_TAG);
                    1: put_transfer(zero_idx, recip, rand_amount(), FL_SHORT);
                    2: put_transfer(zero_idx, recip, rand_amount(), FL_LONG);
                    3: put_transfer(zero_idx, recip, rand_amount(), FL_ONE_ACCT);
                    4: begin
                        prog = n_acc + int'($urandom_range(3));
                        put_transfer(prog, recip, rand_amount(), FL_NONE);
                    end
                    5: put_transfer(zero_idx, n_acc + int'($urandom_range(3)),
                                   rand_amount(), FL_NONE);
                    default: put_transfer($urandom_range(255), recip, rand_amount(), FL_NONE);
                endcase
            end else begin
                put_instr($urandom_range(255), $urandom_range(4), $urandom_range(14));
            end
        end
        if ($urandom_range(4) == 0) put_random($urandom_range(1, 5));
        sel = $urandom_range(99);
        if (sel < 10) begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut) void'(msg_buf.pop_back());
        end else if (sel < 15) begin
            msg_buf[$urandom_range(msg_buf.size() - 1)] ^= 8'($urandom_range(1, 255));
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit eom);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        scan_byte(b, eom);
    endtask

    task automatic send_message(output int n_sent);
        n_sent = msg_buf.size();
        for (int i = 0; i < n_sent; i++) send_byte(msg_buf[i], i == n_sent - 1);
        msg_buf.delete();
    endtask

    // ---------------------------------------------------------------
    // Output side: random back-pressure plus requested long hold-offs
    // ---------------------------------------------------------------
    int holds_served = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left = RX_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_PRINTS)
                    $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_results.pop_front();
                check_field("word_index", 64'(want.idx), 64'(o_m_axis_tuser[1:0]));
                check_field("recipient_word", want.rcpt_word, o_m_axis_tdata[63:0]);
                check_field("amount", want.amount, o_m_axis_tdata[127:64]);
                check_field("status", 64'(want.status), 64'(o_m_axis_tuser[4:2]));
                check_field("last_result", 64'(want.last), 64'(o_m_axis_tlast));
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_header_cases();
        int n;
        msg_buf.push_back(8'h80);
        put_random(5);
        send_message(n);
        msg_buf.push_back(8'hff);          // versioned flag on the final byte itself
        send_message(n);
        msg_buf.push_back(8'h00);          // cut inside the header
        send_message(n);
        msg_buf = '{8'h7f, 8'hff, 8'h00};
        send_message(n);
    endtask

    task automatic test_count_limits();
        int n;
        put_header();
        put_count(ACCTS + 1, 0);
        put_random(40);
        send_message(n);
        put_header();
        put_count(21'h1fffff, 0);
        send_message(n);
        put_header();
        msg_buf.push_back(8'h80);          // overlong account count
        msg_buf.push_back(8'h80);
        msg_buf.push_back(8'h80);
        put_random(3);
        send_message(n);
        put_header();
        put_count(1, 0);
        put_key(FILL_ZERO);
        put_random(HASH_BYTES);
        msg_buf.push_back(8'hff);          // overlong instruction count
        msg_buf.push_back(8'hff);
        msg_buf.push_back(8'hff);
        put_transfer(0, 0, rand_amount(), FL_NONE);
        send_message(n);
        put_header();
        put_count(1, COUNT_MAX_BYTES);
        put_key(FILL_ZERO);
        put_random(HASH_BYTES);
        put_count(21'h1fffff, 0);
        put_transfer(0, 0, rand_amount(), FL_NONE);
        send_message(n);
    endtask

    task automatic test_transfer_found();
        int n;
        put_header();
        put_count(1, 0);
        put_key(FILL_ZERO);
        put_random(HASH_BYTES);
        put_count(1, 0);
        put_transfer(0, 0, '1, FL_NONE);
        send_message(n);
        put_header();
        put_count(ACCTS, 2);
        for (int a = 0; a < ACCTS; a++)
            put_key((a == ACCTS - 2) ? FILL_ZERO : (a == ACCTS - 1) ? FILL_ONES : FILL_RAND);
        put_random(HASH_BYTES);
        put_count(2, 0);
        put_instr(ACCTS - 1, 3, TRANSFER_LEN);
        put_transfer(ACCTS - 2, ACCTS - 1, '0, FL_NONE);
        send_message(n);
        put_header();
        put_count(3, 0);
        put_key(FILL_RAND);
        put_key(FILL_ZERO);
        put_key(FILL_ONES);
        put_random(HASH_BYTES);
        put_count(1, 0);
        put_transfer(1, 0, rand_amount(), FL_NONE);
        put_random(6);
        send_message(n);
    endtask

    task automatic test_transfer_rejects();
        int n;
        put_header();
        put_count(3, 0);
        put_key(FILL_ZERO);
        put_key(FILL_RAND);
        put_key(FILL_RAND);
        put_random(HASH_BYTES);
        put_count(8, 0);
        put_transfer(0, 1, rand_amount(), FL_TAG);
        put_transfer(0, 1, rand_amount(), FL_SHORT);
        put_transfer(0, 1, rand_amount(), FL_LONG);
        put_transfer(0, 1, rand_amount(), FL_ONE_ACCT);
        put_transfer(1, 2, rand_amount(), FL_NONE);   // program key not all zero
        put_transfer(3, 2, rand_amount(), FL_NONE);   // program index past the keys
        put_transfer(0, 3, rand_amount(), FL_NONE);   // recipient past the keys
        put_instr(0, 0, 0);
        put_random(4);
        send_message(n);
    endtask

    task automatic test_first_wins();
        int n;
        put_header();
        put_count(2, 0);
        put_key(FILL_RAND);
        put_key(FILL_ZERO);
        put_random(HASH_BYTES);
        put_count(3, 0);
        put_transfer(1, 0, rand_amount(), FL_NONE);
        put_transfer(1, 1, rand_amount(), FL_NONE);
        msg_buf.push_back(8'h80);          // would be an overlong count; must be ignored
        msg_buf.push_back(8'h80);
        msg_buf.push_back(8'h80);
        send_message(n);
    endtask

    task automatic test_no_transfer();
        int n;
        put_header();
        put_count(0, 0);
        put_random(HASH_BYTES);
        put_count(0, 0);
        put_random(3);
        send_message(n);
        put_header();
        put_count(2, 0);
        put_key(FILL_ZERO);
        put_key(FILL_RAND);
        put_random(HASH_BYTES);
        put_count(2, 0);
        put_instr(0, 1, 3);
        put_instr(5, 0, TRANSFER_LEN);
        put_random(2);
        send_message(n);
    endtask

    // Stall the output long enough that the next final byte is held at the input.
    task automatic test_pressure();
        int n;
        holds_asked++;
        for (int m = 0; m < 4; m++) begin
            msg_buf.push_back(8'h80 | 8'($urandom_range(127)));
            put_random($urandom_range(1, 3));
            send_message(n);
        end
        put_random_message();
        send_message(n);
    endtask

    task automatic test_burst();
        int n;
        no_idle = 1'b1;
        for (int m = 0; m < 4; m++) begin
            put_random_message();
            send_message(n);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int n;
        int byte_total;
        int msg_total;
        byte_total = 0;
        msg_total = 0;
        while (byte_total < RANDOM_BYTES || msg_total < RANDOM_MSGS) begin
            put_random_message();
            send_message(n);
            byte_total += n;
            msg_total++;
        end
    endtask

    initial begin
        clear_scan();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_cases();
        test_count_limits();
        test_transfer_found();
        test_transfer_rejects();
        test_first_wins();
        test_no_transfer();
        test_pressure();
        test_burst();
        test_random();

        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
